FILE: rtl/date_add_days_unit_defines.svh
// ---------------------------------------------------------------------------
// date_add_days_unit_defines.svh
// Assertion macros shared by the date adder checker.
// ---------------------------------------------------------------------------
`ifndef DATE_ADD_DAYS_UNIT_DEFINES_SVH
`define DATE_ADD_DAYS_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define DAD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("date adder check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define DAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("date adder check failed");

`endif

FILE: rtl/dad_pkg.sv
// ---------------------------------------------------------------------------
// dad_pkg
// Types, constants and calendar functions of the date adder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dad_pkg;

    // Field widths
    localparam int OFFSET_BITS = 17;
    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int DD_W        = OFFSET_BITS + 1;
    localparam int S_FIELDS_W  = YEAR_W + MONTH_W + DAY_W + OFFSET_BITS;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = YEAR_W + MONTH_W + DAY_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W   = 2;

    // Calendar constants
    localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;

    // Year / 100 by reciprocal: exact for every 14-bit year
    localparam logic [12:0] RECIP100    = 13'd5243;
    localparam int          RECIP_SHIFT = 19;
    localparam logic [6:0]  CENTURY     = 7'd100;
    localparam logic [6:0]  LAST_IN_CENTURY = 7'd99;

    // Running position of the walk
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [6:0]         cent;
        logic [6:0]         mod100;
        logic [MONTH_W-1:0] month;
        logic [DD_W-1:0]    dd;     // zero-based day in month, two's complement
    } pos_t;

    // Outcome of one month step
    typedef struct packed {
        pos_t nxt;
        logic done;
        logic sat_lo;
        logic sat_hi;
    } step_t;

    // Leap year from year mod 4, year mod 100 and century mod 4
    function automatic logic is_leap(input logic [1:0] y_lo,
                                     input logic [6:0] mod100,
                                     input logic [1:0] cent_lo);
        logic r;
        r = ((y_lo == 2'd0) && (mod100 != 7'd0)) ||
            ((mod100 == 7'd0) && (cent_lo == 2'd0));
        return r;
    endfunction

    // Days in month; zero for a month code that names no month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            MONTH_FEB:                                  r = leap ? 5'd29 : 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/dad_step.sv
// ---------------------------------------------------------------------------
// dad_step
// Shared month step: one add and sign test moves the date by one month, or flags saturation or the end of the walk.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dad_step
(
    input  dad_pkg::pos_t  cur,
    output dad_pkg::step_t res
);

    logic                          leap;
    logic [dad_pkg::DAY_W-1:0]     len;
    logic [dad_pkg::DAY_W-1:0]     prev_len;
    logic [dad_pkg::MONTH_W-1:0]   prev_month;
    logic                          neg;
    logic [dad_pkg::DD_W-1:0]      addend;
    logic [dad_pkg::DD_W-1:0]      sum;

    // Month lengths of this and the previous month
    always_comb
    begin
        leap       = dad_pkg::is_leap(cur.year[1:0], cur.mod100, cur.cent[1:0]);
        len        = dad_pkg::month_len(cur.month, leap);
        prev_month = cur.month - 4'd1;
        prev_len   = (cur.month == dad_pkg::MONTH_JAN) ? 5'd31
                                                       : dad_pkg::month_len(prev_month, leap);
    end

    // Shared adder: add previous length when behind, subtract length otherwise
    always_comb
    begin
        neg    = cur.dd[dad_pkg::DD_W-1];
        addend = neg ? {{(dad_pkg::DD_W-dad_pkg::DAY_W){1'b0}}, prev_len}
                     : {dad_pkg::DD_W{1'b0}} - {{(dad_pkg::DD_W-dad_pkg::DAY_W){1'b0}}, len};
        sum    = cur.dd + addend;
    end

    // Decide: step back, step forward, saturate or finish
    always_comb
    begin
        res     = '0;
        res.nxt = cur;
        if (neg)
        begin
            if (cur.month == dad_pkg::MONTH_JAN && cur.year == '0)
            begin
                res.sat_lo = 1'b1;
            end
            else
            begin
                res.nxt.dd = sum;
                if (cur.month == dad_pkg::MONTH_JAN)
                begin
                    res.nxt.month = dad_pkg::MONTH_DEC;
                    res.nxt.year  = cur.year - 14'd1;
                    if (cur.mod100 == 7'd0)
                    begin
                        res.nxt.mod100 = dad_pkg::LAST_IN_CENTURY;
                        res.nxt.cent   = cur.cent - 7'd1;
                    end
                    else
                    begin
                        res.nxt.mod100 = cur.mod100 - 7'd1;
                    end
                end
                else
                begin
                    res.nxt.month = prev_month;
                end
            end
        end
        else if (!sum[dad_pkg::DD_W-1])
        begin
            if (cur.month == dad_pkg::MONTH_DEC && cur.year == dad_pkg::MAX_YEAR)
            begin
                res.sat_hi = 1'b1;
            end
            else
            begin
                res.nxt.dd = sum;
                if (cur.month == dad_pkg::MONTH_DEC)
                begin
                    res.nxt.month = dad_pkg::MONTH_JAN;
                    res.nxt.year  = cur.year + 14'd1;
                    if (cur.mod100 == dad_pkg::LAST_IN_CENTURY)
                    begin
                        res.nxt.mod100 = 7'd0;
                        res.nxt.cent   = cur.cent + 7'd1;
                    end
                    else
                    begin
                        res.nxt.mod100 = cur.mod100 + 7'd1;
                    end
                end
                else
                begin
                    res.nxt.month = cur.month + 4'd1;
                end
            end
        end
        else
        begin
            res.done = 1'b1;
        end
    end

endmodule

FILE: rtl/date_add_days_unit.sv
// ---------------------------------------------------------------------------
// date_add_days_unit
// Adds a signed day count to a Gregorian date, one month per cycle.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one item: start date and a signed day offset. m_axis
//   returns one item per input: the resulting date plus two flags in tuser
//   (bit 0 invalid start date, bit 1 result saturated outside years 0..9999).
//   An item passes S_DIV and S_CHK, then walks month by month in S_STEP
//   through the shared step unit until the offset is used up or the date
//   saturates, and ends in S_DONE. An invalid date goes from S_CHK
//   straight to S_DONE.
//   s_axis_tready is high only while the unit is idle; one item is in work
//   at a time. A finished item sits in the output register; the next item
//   may be accepted meanwhile, and its result waits until the output frees.
//   Reset clears the sequencer and drops any pending output item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module date_add_days_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // start_year[13:0], start_month[17:14], start_day[22:18], day_offset[39:23]
    input  logic [dad_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // result_year[13:0], result_month[17:14], result_day[22:18], zero pad
    output logic [dad_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // input_invalid[0], out_of_range[1]
    output logic [dad_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_STEP = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam int Y_LO = 0;
    localparam int M_LO = dad_pkg::YEAR_W;
    localparam int D_LO = M_LO + dad_pkg::MONTH_W;
    localparam int O_LO = D_LO + dad_pkg::DAY_W;

    logic [2:0]                         state_reg, state_next;
    logic [dad_pkg::YEAR_W-1:0]         year_reg;
    logic [dad_pkg::MONTH_W-1:0]        month_reg;
    logic [dad_pkg::DAY_W-1:0]          day_reg;
    logic [dad_pkg::OFFSET_BITS-1:0]    off_reg;
    logic [7:0]                         q100_reg;
    dad_pkg::pos_t                      pos_reg, pos_next;
    logic [dad_pkg::M_FIELDS_W-1:0]     res_reg, res_next;
    logic [dad_pkg::M_TUSER_W-1:0]      flags_reg, flags_next;
    logic                               m_valid_reg, m_valid_next;
    logic [dad_pkg::M_FIELDS_W-1:0]     m_data_reg;
    logic [dad_pkg::M_TUSER_W-1:0]      m_user_reg;

    logic                               s_fire;
    logic                               out_free;
    logic [26:0]                        recip_prod;
    logic [14:0]                        cent_prod;
    logic [14:0]                        rem_full;
    logic [6:0]                         r100;
    logic                               chk_leap;
    logic                               chk_bad;
    logic [dad_pkg::DD_W-1:0]           dd_init;
    dad_pkg::step_t                     stp;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Year / 100 by reciprocal, registered before the remainder multiply
    assign recip_prod = year_reg * dad_pkg::RECIP100;

    // Remainder, leap test and date check
    always_comb
    begin
        cent_prod = q100_reg * dad_pkg::CENTURY;
        rem_full  = {1'b0, year_reg} - cent_prod;
        r100      = rem_full[6:0];
        chk_leap  = dad_pkg::is_leap(year_reg[1:0], r100, q100_reg[1:0]);
        chk_bad   = (year_reg > dad_pkg::MAX_YEAR) ||
                    !(month_reg inside {[dad_pkg::MONTH_JAN:dad_pkg::MONTH_DEC]}) ||
                    (day_reg == '0) ||
                    (day_reg > dad_pkg::month_len(month_reg, chk_leap));
        dd_init   = {{(dad_pkg::DD_W-dad_pkg::DAY_W){1'b0}}, day_reg} -
                    {{(dad_pkg::DD_W-1){1'b0}}, 1'b1} +
                    {off_reg[dad_pkg::OFFSET_BITS-1], off_reg};
    end

    dad_step u_step
    (
        .cur (pos_reg),
        .res (stp)
    );

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        res_next     = res_reg;
        flags_next   = flags_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (chk_bad)
                begin
                    res_next   = '0;
                    flags_next = 2'b01;
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next.year   = year_reg;
                    pos_next.cent   = q100_reg[6:0];
                    pos_next.mod100 = r100;
                    pos_next.month  = month_reg;
                    pos_next.dd     = dd_init;
                    state_next      = S_STEP;
                end
            end
            S_STEP:
            begin
                if (stp.sat_lo)
                begin
                    res_next   = {5'd1, dad_pkg::MONTH_JAN, 14'd0};
                    flags_next = 2'b10;
                    state_next = S_DONE;
                end
                else if (stp.sat_hi)
                begin
                    res_next   = {dad_pkg::DAY_LAST_DEC, dad_pkg::MONTH_DEC, dad_pkg::MAX_YEAR};
                    flags_next = 2'b10;
                    state_next = S_DONE;
                end
                else if (stp.done)
                begin
                    res_next   = {pos_reg.dd[dad_pkg::DAY_W-1:0] + 5'd1, pos_reg.month,
                                  pos_reg.year};
                    flags_next = 2'b00;
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next = stp.nxt;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            year_reg  <= s_axis_tdata[M_LO-1:Y_LO];
            month_reg <= s_axis_tdata[D_LO-1:M_LO];
            day_reg   <= s_axis_tdata[O_LO-1:D_LO];
            off_reg   <= s_axis_tdata[O_LO+dad_pkg::OFFSET_BITS-1:O_LO];
        end
        if (state_reg == S_DIV)
        begin
            q100_reg <= recip_prod[dad_pkg::RECIP_SHIFT+7:dad_pkg::RECIP_SHIFT];
        end
        pos_reg   <= pos_next;
        res_reg   <= res_next;
        flags_reg <= flags_next;
        if (state_reg == S_DONE && out_free)
        begin
            m_data_reg <= res_reg;
            m_user_reg <= flags_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(dad_pkg::M_TDATA_W-dad_pkg::M_FIELDS_W){1'b0}}, m_data_reg};
    assign m_axis_tuser  = m_user_reg;

endmodule

FILE: rtl/dad_checker.sv
// ---------------------------------------------------------------------------
// dad_checker
// Port-level checks of the date adder, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "date_add_days_unit_defines.svh"

module dad_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [dad_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic [dad_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    logic [dad_pkg::YEAR_W-1:0]  o_year;
    logic [dad_pkg::MONTH_W-1:0] o_month;
    logic [dad_pkg::DAY_W-1:0]   o_day;

    assign o_year  = m_axis_tdata[13:0];
    assign o_month = m_axis_tdata[17:14];
    assign o_day   = m_axis_tdata[22:18];

    // Hold a stalled output item
    `DAD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // Take one item at a time: not ready right after an accept
    `DAD_ASSERT_NEXT(a_one_in_work, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // Invalid start date gives a zero date and no range flag
    `DAD_ASSERT_IMPL(a_invalid_zero, m_axis_tvalid && m_axis_tuser[0],
                     o_year == '0 && o_month == '0 && o_day == '0 && !m_axis_tuser[1])

    // A normal result is a real calendar date
    `DAD_ASSERT_IMPL(a_result_date, m_axis_tvalid && !m_axis_tuser[0],
                     o_month != '0 && o_month <= 4'd12 && o_day != '0 && o_year <= 14'd9999)

    // Range flag only with a saturated date
    `DAD_ASSERT_IMPL(a_sat_date, m_axis_tvalid && m_axis_tuser[1],
                     (o_year == 14'd0 && o_month == 4'd1 && o_day == 5'd1) ||
                     (o_year == 14'd9999 && o_month == 4'd12 && o_day == 5'd31))

endmodule

bind date_add_days_unit dad_checker u_dad_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
